/* rtl/nps_pkg.sv */
// Shared widths, action codes and result type for the nearest pending set.
`default_nettype none
package nps_pkg;

  localparam int ACT_W     = 2;
  localparam int LOC_W     = 16;
  localparam int POS_W     = 24;
  localparam int RAD_W     = 8;
  localparam int CNT_OUT_W = 7;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PURGE  = 2'd2;

  typedef struct packed {
    logic                        found;
    logic signed [LOC_W-1:0]     out_x;
    logic signed [LOC_W-1:0]     out_y;
    logic signed [LOC_W-1:0]     out_z;
    logic                        dropped;
    logic [CNT_OUT_W-1:0]        removed_count;
    logic [CNT_OUT_W-1:0]        occupancy;
  } res_t;

endpackage
`default_nettype wire

/* rtl/nps_in_if.sv */
// Action channel: valid/ready handshake with the action payload.
`default_nettype none
interface nps_in_if import nps_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [LOC_W-1:0] loc_x;
  logic signed [LOC_W-1:0] loc_y;
  logic signed [LOC_W-1:0] loc_z;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [RAD_W-1:0]        radius;

  modport source (output valid, action, loc_x, loc_y, loc_z, pos_x, pos_y, pos_z, radius,
                  input ready);
  modport sink (input valid, action, loc_x, loc_y, loc_z, pos_x, pos_y, pos_z, radius,
                output ready);
endinterface
`default_nettype wire

/* rtl/nps_out_if.sv */
// Result channel: valid/ready handshake with the result payload.
`default_nettype none
interface nps_out_if import nps_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [LOC_W-1:0] out_x;
  logic signed [LOC_W-1:0] out_y;
  logic signed [LOC_W-1:0] out_z;
  logic                    dropped;
  logic [CNT_OUT_W-1:0]    removed_count;
  logic [CNT_OUT_W-1:0]    occupancy;

  modport source (output valid, found, out_x, out_y, out_z, dropped, removed_count, occupancy,
                  input ready);
  modport sink (input valid, found, out_x, out_y, out_z, dropped, removed_count, occupancy,
                output ready);
endinterface
`default_nettype wire

/* rtl/nps_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module nps_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/nearest_pending_set.sv */
// Nearest pending set: scans a slot RAM to insert, pop the nearest entry or purge far entries.
//
// The set lives in one RAM of SET_DEPTH words, each a valid bit and three COORD_BITS signed
// coordinates. Every transaction scans the whole RAM through its single read port, one slot
// per cycle. After the reads the distance pipeline (read, difference, square, sum and compare)
// drains; the control then sees the pipeline empty, writes back and loads the output register,
// waiting while an earlier result is still held there. Insert looks for a duplicate and the
// lowest free slot and writes the new entry at the end of the scan; pop keeps the least
// squared distance (lowest slot on ties) and clears that slot at the end; purge clears
// out-of-radius slots as they are read. One action is processed at a time; the next
// transaction is accepted while a result still waits in the output register. After reset a
// clearing pass zeroes the RAM, and no transaction is accepted until it ends. removed_count
// and occupancy saturate at 127.
`default_nettype none
module nearest_pending_set import nps_pkg::*; #(
  parameter int SET_DEPTH     = 64,
  parameter int COORD_BITS    = 16,
  parameter int POS_FRAC_BITS = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  nps_in_if.sink    in_ch,
  nps_out_if.source out_ch
);

  localparam int AW    = $clog2(SET_DEPTH);
  localparam int IW    = AW + 1;
  localparam int CNT_W = $clog2(SET_DEPTH + 1);
  localparam int CW    = COORD_BITS;
  localparam int WW    = 3 * CW + 1;
  // signed difference width for pop: scaled cell minus position
  localparam int DW    = ((CW + POS_FRAC_BITS > POS_W) ? CW + POS_FRAC_BITS : POS_W) + 1;
  localparam int MW    = DW;
  localparam int SQ_W  = 2 * MW;
  localparam int SUM_W = 2 * MW + 2;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  function automatic logic [CNT_OUT_W-1:0] sat7(input logic [CNT_W-1:0] v);
    return (32'(v) > 32'd127) ? 7'd127 : CNT_OUT_W'(v);
  endfunction

  logic [1:0]             state;
  logic [IW-1:0]          iss_cnt;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       cnt_next;

  // latched transaction
  logic [ACT_W-1:0]       act_r;
  logic signed [CW-1:0]   loc_r [3];
  logic signed [POS_W-1:0] pos_r [3];
  logic [RAD_W-1:0]       rad_r;

  // RAM
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [WW-1:0]          wdata;
  logic                   issue;
  logic [WW-1:0]          rdata;

  // scan pipeline
  logic                   p0_vld;
  logic [AW-1:0]          p0_idx;
  logic                   a_vld, b_vld, c_vld;
  logic [AW-1:0]          a_idx, b_idx, c_idx;
  logic [3*CW-1:0]        a_coord, b_coord, c_coord;
  logic [MW-1:0]          a_mag [3];
  logic [SQ_W-1:0]        b_sq [3];
  logic [SUM_W-1:0]       c_sum;

  // per-action scan results
  logic                   dup, free_vld;
  logic [AW-1:0]          free_idx;
  logic [CNT_W-1:0]       rm_cnt;
  logic                   best_vld;
  logic [AW-1:0]          best_idx;
  logic [SUM_W-1:0]       best_sum;
  logic [3*CW-1:0]        best_coord;

  // slot decode
  logic                   r_vld;
  logic signed [CW-1:0]   r_c [3];
  logic signed [DW-1:0]   pd [3];
  logic signed [CW:0]     cd [3];
  logic [CW:0]            cmag [3];
  logic                   far, r_match;
  logic                   purge_rm, best_upd;

  logic                   in_acc, scan_done, fin, do_ins, do_pop;
  logic                   out_vld;
  res_t                   out_res;
  res_t                   res_next;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign issue       = (state == ST_SCAN) && (iss_cnt != IW'(SET_DEPTH));
  assign scan_done   = (iss_cnt == IW'(SET_DEPTH)) && !p0_vld && !a_vld && !b_vld && !c_vld;
  assign fin         = (state == ST_FINISH) && (!out_vld || out_ch.ready);
  assign do_ins      = (act_r == ACT_INSERT) && !dup && free_vld;
  assign do_pop      = (act_r == ACT_POP) && best_vld;

  nps_ram #(
    .WIDTH (WW),
    .DEPTH (SET_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (iss_cnt[AW-1:0]),
    .rdata (rdata)
  );

  // decode the slot word that just came out of the RAM
  always_comb begin
    r_vld   = rdata[WW-1];
    r_match = 1'b1;
    far     = 1'b0;
    for (int k = 0; k < 3; k++) begin
      r_c[k]  = signed'(rdata[k*CW +: CW]);
      pd[k]   = (DW'(r_c[k]) <<< POS_FRAC_BITS) - DW'(pos_r[k]);
      cd[k]   = (CW+1)'(r_c[k]) - (CW+1)'(loc_r[k]);
      cmag[k] = cd[k][CW] ? unsigned'(-cd[k]) : unsigned'(cd[k]);
      if (r_c[k] != loc_r[k]) r_match = 1'b0;
      if (cmag[k] > (CW+1)'(rad_r)) far = 1'b1;
    end
  end

  assign purge_rm = p0_vld && (act_r == ACT_PURGE) && r_vld && far;
  assign best_upd = c_vld && (!best_vld || (c_sum < best_sum));

  // single write port: clearing pass, purge write-back, end-of-scan update
  always_comb begin
    we    = 1'b0;
    waddr = iss_cnt[AW-1:0];
    wdata = '0;
    priority if (state == ST_CLEAR) begin
      we = 1'b1;
    end else if (purge_rm) begin
      we    = 1'b1;
      waddr = p0_idx;
      wdata = {1'b0, rdata[3*CW-1:0]};
    end else if (fin && do_ins) begin
      we    = 1'b1;
      waddr = free_idx;
      wdata = {1'b1, loc_r[2], loc_r[1], loc_r[0]};
    end else if (fin && do_pop) begin
      we    = 1'b1;
      waddr = best_idx;
      wdata = {1'b0, best_coord};
    end
  end

  always_comb begin
    unique case (act_r)
      ACT_INSERT: cnt_next = do_ins ? cnt + CNT_W'(1) : cnt;
      ACT_POP:    cnt_next = best_vld ? cnt - CNT_W'(1) : cnt;
      ACT_PURGE:  cnt_next = cnt - rm_cnt;
      default:    cnt_next = cnt;
    endcase
  end

  always_comb begin
    res_next               = '0;
    res_next.found         = do_pop;
    res_next.out_x         = do_pop ? LOC_W'(best_coord[0*CW +: CW]) : '0;
    res_next.out_y         = do_pop ? LOC_W'(best_coord[1*CW +: CW]) : '0;
    res_next.out_z         = do_pop ? LOC_W'(best_coord[2*CW +: CW]) : '0;
    res_next.dropped       = (act_r == ACT_INSERT) && !dup && !free_vld;
    res_next.removed_count = (act_r == ACT_PURGE) ? sat7(rm_cnt) : '0;
    res_next.occupancy     = sat7(cnt_next);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      iss_cnt  <= '0;
      cnt      <= '0;
      p0_vld   <= 1'b0;
      a_vld    <= 1'b0;
      b_vld    <= 1'b0;
      c_vld    <= 1'b0;
      dup      <= 1'b0;
      free_vld <= 1'b0;
      rm_cnt   <= '0;
      best_vld <= 1'b0;
      out_vld  <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (iss_cnt == IW'(SET_DEPTH - 1)) begin
            state   <= ST_IDLE;
            iss_cnt <= '0;
          end else begin
            iss_cnt <= iss_cnt + IW'(1);
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            state    <= ST_SCAN;
            iss_cnt  <= '0;
            dup      <= 1'b0;
            free_vld <= 1'b0;
            rm_cnt   <= '0;
            best_vld <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (issue) iss_cnt <= iss_cnt + IW'(1);
          if (scan_done) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (fin) begin
            state <= ST_IDLE;
            cnt   <= cnt_next;
          end
        end
      endcase

      p0_vld <= issue;
      a_vld  <= p0_vld && r_vld && (act_r == ACT_POP);
      b_vld  <= a_vld;
      c_vld  <= b_vld;

      if (p0_vld && (act_r == ACT_INSERT)) begin
        if (r_vld && r_match) dup <= 1'b1;
        if (!r_vld && !free_vld) free_vld <= 1'b1;
      end
      if (purge_rm) rm_cnt <= rm_cnt + CNT_W'(1);
      if (best_upd) best_vld <= 1'b1;

      if (fin) begin
        out_vld <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r    <= in_ch.action;
      loc_r[0] <= signed'(CW'($unsigned(in_ch.loc_x)));
      loc_r[1] <= signed'(CW'($unsigned(in_ch.loc_y)));
      loc_r[2] <= signed'(CW'($unsigned(in_ch.loc_z)));
      pos_r[0] <= in_ch.pos_x;
      pos_r[1] <= in_ch.pos_y;
      pos_r[2] <= in_ch.pos_z;
      rad_r    <= in_ch.radius;
    end
    if (issue) p0_idx <= iss_cnt[AW-1:0];
    if (p0_vld && !free_vld && !r_vld) free_idx <= p0_idx;

    // difference magnitude, square, sum: one register per step
    a_idx   <= p0_idx;
    a_coord <= rdata[3*CW-1:0];
    for (int k = 0; k < 3; k++) begin
      a_mag[k] <= pd[k][DW-1] ? MW'(unsigned'(-pd[k])) : MW'(unsigned'(pd[k]));
      b_sq[k]  <= SQ_W'(a_mag[k]) * SQ_W'(a_mag[k]);
    end
    b_idx   <= a_idx;
    b_coord <= a_coord;
    c_sum   <= SUM_W'(b_sq[0]) + SUM_W'(b_sq[1]) + SUM_W'(b_sq[2]);
    c_idx   <= b_idx;
    c_coord <= b_coord;

    if (best_upd) begin
      best_idx   <= c_idx;
      best_sum   <= c_sum;
      best_coord <= c_coord;
    end
    if (fin) out_res <= res_next;
  end

  assign out_ch.valid         = out_vld;
  assign out_ch.found         = out_res.found;
  assign out_ch.out_x         = out_res.out_x;
  assign out_ch.out_y         = out_res.out_y;
  assign out_ch.out_z         = out_res.out_z;
  assign out_ch.dropped       = out_res.dropped;
  assign out_ch.removed_count = out_res.removed_count;
  assign out_ch.occupancy     = out_res.occupancy;

endmodule
`default_nettype wire

/* rtl/nps_checker.sv */
// Port-level checks on the nearest pending set, bound to the top level.
`default_nettype none
module nps_checker import nps_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 found,
  input wire logic [LOC_W-1:0]     out_x,
  input wire logic [LOC_W-1:0]     out_y,
  input wire logic [LOC_W-1:0]     out_z,
  input wire logic                 dropped,
  input wire logic [CNT_OUT_W-1:0] removed_count,
  input wire logic [CNT_OUT_W-1:0] occupancy
);

  logic                    in_acc, out_acc;
  logic [1:0]              pend;
  logic [CNT_OUT_W-1:0]    prev_occ;
  logic [3*LOC_W+2*CNT_OUT_W+1:0] payload;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign payload = {found, out_x, out_y, out_z, dropped, removed_count, occupancy};

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= '0;
      prev_occ <= '0;
    end else begin
      pend <= pend + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) prev_occ <= occupancy;
    end
  end

  // a pop that returns an entry shrinks the set by one
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    out_acc && found && (prev_occ < 7'd127) |-> (occupancy + 7'd1 == prev_occ))
    else $error("pop result does not reduce occupancy by one");

  // a dropped insert leaves the set as it was
  a_drop_keeps: assert property (@(posedge clk) disable iff (rst)
    out_acc && dropped |-> (occupancy == prev_occ))
    else $error("dropped insert changed occupancy");

  // the clearing pass holds off new transactions right after reset
  a_clear_busy: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("transaction accepted during clearing pass");

  // every result belongs to an accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pend != 2'd0))
    else $error("result without a pending transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload))
    else $error("stalled result changed");

endmodule

bind nearest_pending_set nps_checker u_nps_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .found         (out_ch.found),
  .out_x         (out_ch.out_x),
  .out_y         (out_ch.out_y),
  .out_z         (out_ch.out_z),
  .dropped       (out_ch.dropped),
  .removed_count (out_ch.removed_count),
  .occupancy     (out_ch.occupancy)
);
`default_nettype wire
